>>> hdl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Shared phase codes, byte constants, result types and name tables.
// ----------------------------------------------------------------------------
package hrhp_pkg;

    localparam logic [3:0] PH_METHOD = 4'd0;
    localparam logic [3:0] PH_QUERY  = 4'd1;
    localparam logic [3:0] PH_PROTO  = 4'd2;
    localparam logic [3:0] PH_REQ_LF = 4'd3;
    localparam logic [3:0] PH_LINE   = 4'd4;
    localparam logic [3:0] PH_NAME   = 4'd5;
    localparam logic [3:0] PH_VALUE  = 4'd6;
    localparam logic [3:0] PH_VAL_LF = 4'd7;
    localparam logic [3:0] PH_END_LF = 4'd8;
    localparam logic [3:0] PH_DONE   = 4'd9;

    localparam int NUM_HDRS = 13;
    localparam logic [3:0] HDR_NONE = 4'd13;

    localparam logic [2:0] CLS_METHOD = 3'd0;
    localparam logic [2:0] CLS_SPACE  = 3'd1;
    localparam logic [2:0] CLS_QUERY  = 3'd2;
    localparam logic [2:0] CLS_PROTO  = 3'd3;
    localparam logic [2:0] CLS_BREAK  = 3'd4;
    localparam logic [2:0] CLS_NAME   = 3'd5;
    localparam logic [2:0] CLS_SEP    = 3'd6;
    localparam logic [2:0] CLS_VALUE  = 3'd7;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_REQ   = 2'd1;
    localparam logic [1:0] ERR_HDR   = 2'd2;
    localparam logic [1:0] ERR_EMPTY = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [2:0] token_class;
        logic [3:0] header_id;
        logic [1:0] method_code;
        logic       protocol_code;
        logic       head_done;
        logic       parse_error;
        logic [1:0] error_kind;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } item_t;

    function automatic logic [4:0] hdr_len(input int k);
        case (k)
            0: hdr_len = 5'd10;  1: hdr_len = 5'd14;  2: hdr_len = 5'd17;
            3: hdr_len = 5'd4;   4: hdr_len = 5'd6;   5: hdr_len = 5'd10;
            6: hdr_len = 5'd15;  7: hdr_len = 5'd15;  8: hdr_len = 5'd13;
            9: hdr_len = 5'd13;  10: hdr_len = 5'd12; 11: hdr_len = 5'd7;
            default: hdr_len = 5'd6;
        endcase
    endfunction

    function automatic logic [8*17-1:0] hdr_text(input int k);
        case (k)
            0: hdr_text = "connection";
            1: hdr_text = "content-length";
            2: hdr_text = "transfer-encoding";
            3: hdr_text = "host";
            4: hdr_text = "accept";
            5: hdr_text = "user-agent";
            6: hdr_text = "accept-encoding";
            7: hdr_text = "accept-language";
            8: hdr_text = "if-none-match";
            9: hdr_text = "cache-control";
            10: hdr_text = "content-type";
            11: hdr_text = "referer";
            default: hdr_text = "origin";
        endcase
    endfunction

    // Character at position pos of known name k, zero beyond its end.
    function automatic logic [7:0] hdr_char(input int k, input logic [4:0] pos);
        logic [8*17-1:0] t;
        logic [4:0] n;
        t = hdr_text(k);
        n = hdr_len(k);
        if (pos < n)
            hdr_char = t[8*(int'(n) - 1 - int'(pos)) +: 8];
        else
            hdr_char = 8'h00;
    endfunction

    function automatic logic [7:0] meth_char(input int k, input logic [4:0] pos);
        logic [31:0] t;
        case (k)
            0: t = {"GET", 8'h00};
            1: t = "HEAD";
            default: t = "POST";
        endcase
        meth_char = (pos < 5'd4) ? t[8*(3 - int'(pos[1:0])) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] proto_char(input int k, input logic [4:0] pos);
        logic [63:0] t;
        t = (k == 0) ? "HTTP/1.0" : "HTTP/1.1";
        proto_char = t[8*(7 - int'(pos[2:0])) +: 8];
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        is_name_char = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                       (b >= "0" && b <= "9") || b == "-";
    endfunction

endpackage

>>> hdl/http_request_head_parser_unit.sv
// ----------------------------------------------------------------------------
// HTTP request head parser unit
// Top level: input register, parser core and output register.
// ----------------------------------------------------------------------------
// The unit takes one byte of an HTTP request head per cycle while the output
// is free and returns one tagged result per byte, through the input register
// and then the output register. An item that waits at the output holds the
// input register, and otherwise the unit accepts one item per cycle.
module http_request_head_parser_unit
    import hrhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] token_class,
    output logic [3:0] header_id,
    output logic [1:0] method_code,
    output logic       protocol_code,
    output logic       head_done,
    output logic       parse_error,
    output logic [1:0] error_kind
);

    logic    ivalid_reg;
    item_t   item_reg;
    logic    ovalid_reg;
    result_t res_reg;
    result_t res_comb;
    logic    step;

    assign step     = ivalid_reg && (!ovalid_reg || out_ready);
    assign in_ready = !ivalid_reg || step;

    hrhp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .result (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                ivalid_reg <= in_valid;
            if (step)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{data_byte: data_byte, restart: restart};
        if (step)
            res_reg <= res_comb;
    end

    assign out_valid     = ovalid_reg;
    assign token_class   = res_reg.token_class;
    assign header_id     = res_reg.header_id;
    assign method_code   = res_reg.method_code;
    assign protocol_code = res_reg.protocol_code;
    assign head_done     = res_reg.head_done;
    assign parse_error   = res_reg.parse_error;
    assign error_kind    = res_reg.error_kind;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(res_reg)))
        else $error("result lost under stall");
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("processed item not presented");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ivalid_reg && !step) |-> !in_ready)
        else $error("input register overwritten");

endmodule

>>> hdl/hrhp_name_match.sv
// ----------------------------------------------------------------------------
// Header name matcher
// Compares one lower-cased name byte against all known names in parallel and
// resolves the known index at the colon.
// ----------------------------------------------------------------------------
module hrhp_name_match
    import hrhp_pkg::*;
(
    input  logic [7:0]          data_byte,
    input  logic [4:0]          position,
    input  logic [NUM_HDRS-1:0] candidates,
    output logic [NUM_HDRS-1:0] next_candidates,
    output logic [3:0]          found_id
);

    logic [7:0] lc;

    always_comb
    begin
        lc = (data_byte >= "A" && data_byte <= "Z") ? (data_byte | 8'h20) : data_byte;
        for (int k = 0; k < NUM_HDRS; k++)
        begin
            next_candidates[k] = candidates[k] && (position < hdr_len(k)) &&
                                 (lc == hdr_char(k, position));
        end
        found_id = HDR_NONE;
        for (int k = NUM_HDRS - 1; k >= 0; k--)
        begin
            if (candidates[k] && position == hdr_len(k))
                found_id = 4'(k);
        end
    end

endmodule

>>> hdl/hrhp_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Holds the parser state and works out one result from one registered byte.
// ----------------------------------------------------------------------------
module hrhp_core
    import hrhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [3:0]          phase_reg, phase_next;
    logic [4:0]          pos_reg, pos_next;
    logic [NUM_HDRS-1:0] names_reg, names_next;
    logic [2:0]          meths_reg, meths_next;
    logic [1:0]          protos_reg, protos_next;
    logic [1:0]          meth_reg, meth_next;
    logic                proto_reg, proto_next;
    logic [3:0]          hdr_reg, hdr_next;
    logic                nonempty_reg, nonempty_next;
    logic [1:0]          err_reg, err_next;

    logic [3:0]          ph;
    logic [4:0]          pos;
    logic [NUM_HDRS-1:0] names;
    logic [2:0]          meths;
    logic [1:0]          protos;
    logic [1:0]          meth;
    logic                proto;
    logic [3:0]          hdr;
    logic                nonempty;
    logic [1:0]          err_cur;

    logic [4:0]          match_pos;
    logic [NUM_HDRS-1:0] match_in, match_out;
    logic [3:0]          match_id;
    logic [7:0]          b;
    logic [2:0]          nc3;
    logic [1:0]          nc2;
    logic [1:0]          err;
    logic                meth_ok;
    logic [1:0]          meth_sel;

    hrhp_name_match u_match (
        .data_byte       (item.data_byte),
        .position        (match_pos),
        .candidates      (match_in),
        .next_candidates (match_out),
        .found_id        (match_id)
    );

    always_comb
    begin
        b = item.data_byte;
        if (item.restart)
        begin
            ph = PH_METHOD; pos = '0; names = '1; meths = '1; protos = '1;
            meth = '0; proto = 1'b0; hdr = HDR_NONE; nonempty = 1'b0; err_cur = ERR_NONE;
        end
        else
        begin
            ph = phase_reg; pos = pos_reg; names = names_reg; meths = meths_reg;
            protos = protos_reg; meth = meth_reg; proto = proto_reg; hdr = hdr_reg;
            nonempty = nonempty_reg; err_cur = err_reg;
        end

        match_pos = (ph == PH_LINE) ? 5'd0 : pos;
        match_in  = (ph == PH_LINE) ? '1 : names;

        nc3 = '0;
        meth_ok = 1'b0;
        meth_sel = meth;
        for (int k = 0; k < 3; k++)
        begin
            nc3[k] = meths[k] && (b == meth_char(k, pos)) && (b != 8'h00);
            if (meths[k] && pos == ((k == 0) ? 5'd3 : 5'd4))
            begin
                meth_ok = 1'b1;
                meth_sel = 2'(k);
            end
        end
        for (int k = 0; k < 2; k++)
            nc2[k] = protos[k] && (b == proto_char(k, pos));

        phase_next = ph; pos_next = pos; names_next = names; meths_next = meths;
        protos_next = protos; meth_next = meth; proto_next = proto; hdr_next = hdr;
        nonempty_next = nonempty; err_next = err_cur;
        err = ERR_NONE;
        result = '0;
        result.header_id = HDR_NONE;

        if (err_cur == ERR_NONE)
        begin
            case (ph)
                PH_METHOD:
                    if (b == CH_SPACE)
                    begin
                        if (meth_ok)
                        begin
                            meth_next = meth_sel;
                            result.token_class = CLS_SPACE;
                            phase_next = PH_QUERY;
                            nonempty_next = 1'b0;
                        end
                        else
                            err = ERR_REQ;
                    end
                    else if (nc3 == '0)
                        err = ERR_REQ;
                    else
                    begin
                        meths_next = nc3;
                        pos_next = pos + 5'd1;
                        result.token_class = CLS_METHOD;
                    end
                PH_QUERY:
                    if (b >= 8'h21 && b <= 8'h7E)
                    begin
                        result.token_class = CLS_QUERY;
                        nonempty_next = 1'b1;
                    end
                    else if (b == CH_SPACE && nonempty)
                    begin
                        result.token_class = CLS_SPACE;
                        phase_next = PH_PROTO;
                        pos_next = '0;
                        protos_next = '1;
                    end
                    else
                        err = ERR_REQ;
                PH_PROTO:
                    if (pos >= 5'd8)
                    begin
                        if (b == CH_CR && protos != '0)
                        begin
                            proto_next = !protos[0];
                            result.token_class = CLS_BREAK;
                            phase_next = PH_REQ_LF;
                        end
                        else
                            err = ERR_REQ;
                    end
                    else if (nc2 == '0)
                        err = ERR_REQ;
                    else
                    begin
                        protos_next = nc2;
                        pos_next = pos + 5'd1;
                        result.token_class = CLS_PROTO;
                    end
                PH_REQ_LF:
                    if (b == CH_LF)
                    begin
                        result.token_class = CLS_BREAK;
                        phase_next = PH_LINE;
                    end
                    else
                        err = ERR_REQ;
                PH_LINE, PH_NAME:
                    if (is_name_char(b))
                    begin
                        names_next = match_out;
                        pos_next = (match_pos < 5'd31) ? match_pos + 5'd1 : match_pos;
                        if (ph == PH_LINE)
                            hdr_next = HDR_NONE;
                        result.token_class = CLS_NAME;
                        phase_next = PH_NAME;
                    end
                    else if (ph == PH_LINE && b == CH_CR)
                    begin
                        result.token_class = CLS_BREAK;
                        phase_next = PH_END_LF;
                    end
                    else if (ph == PH_NAME && b == CH_COLON)
                    begin
                        hdr_next = match_id;
                        nonempty_next = 1'b0;
                        phase_next = PH_VALUE;
                        result.token_class = CLS_SEP;
                        result.header_id = match_id;
                    end
                    else
                        err = ERR_HDR;
                PH_VALUE:
                    if (b == CH_SPACE && !nonempty)
                    begin
                        result.token_class = CLS_SEP;
                        result.header_id = hdr;
                    end
                    else if (b >= 8'h20 && b <= 8'h7E)
                    begin
                        result.token_class = CLS_VALUE;
                        result.header_id = hdr;
                        nonempty_next = 1'b1;
                    end
                    else if (b == CH_CR)
                    begin
                        if (nonempty)
                        begin
                            result.token_class = CLS_BREAK;
                            phase_next = PH_VAL_LF;
                        end
                        else
                            err = ERR_EMPTY;
                    end
                    else
                        err = ERR_HDR;
                PH_VAL_LF, PH_END_LF:
                    if (b == CH_LF)
                    begin
                        result.token_class = CLS_BREAK;
                        result.head_done = (ph == PH_END_LF);
                        phase_next = (ph == PH_END_LF) ? PH_DONE : PH_LINE;
                    end
                    else
                        err = ERR_HDR;
                default:
                    ;
            endcase
            if (err != ERR_NONE)
            begin
                err_next = err;
                result.token_class = CLS_METHOD;
                result.header_id = HDR_NONE;
                result.head_done = 1'b0;
            end
        end
        result.method_code = meth_next;
        result.protocol_code = proto_next;
        result.parse_error = (err_next != ERR_NONE);
        result.error_kind = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD; pos_reg <= '0; names_reg <= '1; meths_reg <= '1;
            protos_reg <= '1; meth_reg <= '0; proto_reg <= 1'b0; hdr_reg <= HDR_NONE;
            nonempty_reg <= 1'b0; err_reg <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next; pos_reg <= pos_next; names_reg <= names_next;
            meths_reg <= meths_next; protos_reg <= protos_next; meth_reg <= meth_next;
            proto_reg <= proto_next; hdr_reg <= hdr_next; nonempty_reg <= nonempty_next;
            err_reg <= err_next;
        end
    end

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE && step && !item.restart) |=> err_reg == $past(err_reg))
        else $error("error state changed without restart");
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.head_done) |=> phase_reg == PH_DONE)
        else $error("head end without done phase");
    a_err_class: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.parse_error) |-> (result.token_class == CLS_METHOD &&
        result.header_id == HDR_NONE && !result.head_done))
        else $error("error result carries a token");

endmodule

>>> dv/hrhp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser checker
// Watches both channels, predicts each result from the accepted bytes and
// compares every field of every result in order.
// ----------------------------------------------------------------------------
module hrhp_checker
    import hrhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       restart,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] token_class,
    input  logic [3:0] header_id,
    input  logic [1:0] method_code,
    input  logic       protocol_code,
    input  logic       head_done,
    input  logic       parse_error,
    input  logic [1:0] error_kind,
    output int         failures,
    output int         pending
);

    logic [3:0]  phase;
    logic [4:0]  lit_pos;
    logic [12:0] name_cand;
    logic [2:0]  meth_cand;
    logic [1:0]  proto_cand;
    logic [1:0]  cur_method;
    logic        cur_proto;
    logic [3:0]  cur_hdr;
    logic        nonempty;
    logic [1:0]  err_state;

    result_t expected_results[$];

    assign pending = expected_results.size();

    function automatic logic [4:0] name_length(input int k);
        case (k)
            0: name_length = 5'd10;  1: name_length = 5'd14;  2: name_length = 5'd17;
            3: name_length = 5'd4;   4: name_length = 5'd6;   5: name_length = 5'd10;
            6: name_length = 5'd15;  7: name_length = 5'd15;  8: name_length = 5'd13;
            9: name_length = 5'd13;  10: name_length = 5'd12; 11: name_length = 5'd7;
            default: name_length = 5'd6;
        endcase
    endfunction

    function automatic string name_string(input int k);
        string names[13];
        names = '{"connection", "content-length", "transfer-encoding", "host",
                  "accept", "user-agent", "accept-encoding", "accept-language",
                  "if-none-match", "cache-control", "content-type", "referer",
                  "origin"};
        return names[k];
    endfunction

    function automatic logic name_byte(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "-";
    endfunction

    function automatic void clear_parser();
        phase = PH_METHOD;
        lit_pos = '0;
        name_cand = 13'h1FFF;
        meth_cand = 3'b111;
        proto_cand = 2'b11;
        cur_method = '0;
        cur_proto = 1'b0;
        cur_hdr = HDR_NONE;
        nonempty = 1'b0;
        err_state = ERR_NONE;
    endfunction

    function automatic void advance_name(input logic [7:0] b);
        logic [7:0]  lc;
        logic [12:0] nc;
        string       s;
        lc = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
        nc = '0;
        for (int k = 0; k < NUM_HDRS; k++)
        begin
            s = name_string(k);
            if (name_cand[k] && lit_pos < name_length(k) && lc == s[lit_pos])
                nc[k] = 1'b1;
        end
        name_cand = nc;
        if (lit_pos < 5'd31)
            lit_pos++;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic rs);
        result_t     r;
        logic [2:0]  cls;
        logic [3:0]  hid;
        logic        done;
        logic [1:0]  err;
        logic [2:0]  mc;
        logic [1:0]  pc;
        string       mt[3];
        string       pt;
        mt = '{"GET", "HEAD", "POST"};
        cls = CLS_METHOD;
        hid = HDR_NONE;
        done = 1'b0;
        err = ERR_NONE;
        if (rs)
            clear_parser();
        if (err_state == ERR_NONE)
        begin
            case (phase)
                PH_METHOD:
                    if (b == CH_SPACE)
                    begin
                        err = ERR_REQ;
                        for (int k = 0; k < 3; k++)
                            if (meth_cand[k] && lit_pos == mt[k].len())
                            begin
                                cur_method = 2'(k);
                                err = ERR_NONE;
                            end
                        if (err == ERR_NONE)
                        begin
                            cls = CLS_SPACE;
                            phase = PH_QUERY;
                            nonempty = 1'b0;
                        end
                    end
                    else
                    begin
                        mc = '0;
                        for (int k = 0; k < 3; k++)
                            if (meth_cand[k] && lit_pos < mt[k].len() && b == mt[k][lit_pos])
                                mc[k] = 1'b1;
                        if (mc == '0)
                            err = ERR_REQ;
                        else
                        begin
                            meth_cand = mc;
                            lit_pos++;
                        end
                    end
                PH_QUERY:
                    if (b >= 8'h21 && b <= 8'h7E)
                    begin
                        cls = CLS_QUERY;
                        nonempty = 1'b1;
                    end
                    else if (b == CH_SPACE && nonempty)
                    begin
                        cls = CLS_SPACE;
                        phase = PH_PROTO;
                        lit_pos = '0;
                        proto_cand = 2'b11;
                    end
                    else
                        err = ERR_REQ;
                PH_PROTO:
                    if (lit_pos >= 5'd8)
                    begin
                        if (b == CH_CR && proto_cand != '0)
                        begin
                            cur_proto = !proto_cand[0];
                            cls = CLS_BREAK;
                            phase = PH_REQ_LF;
                        end
                        else
                            err = ERR_REQ;
                    end
                    else
                    begin
                        pc = '0;
                        for (int k = 0; k < 2; k++)
                        begin
                            pt = (k == 0) ? "HTTP/1.0" : "HTTP/1.1";
                            if (proto_cand[k] && b == pt[lit_pos])
                                pc[k] = 1'b1;
                        end
                        if (pc == '0)
                            err = ERR_REQ;
                        else
                        begin
                            proto_cand = pc;
                            lit_pos++;
                            cls = CLS_PROTO;
                        end
                    end
                PH_REQ_LF:
                    if (b == CH_LF)
                    begin
                        cls = CLS_BREAK;
                        phase = PH_LINE;
                    end
                    else
                        err = ERR_REQ;
                PH_LINE:
                    if (name_byte(b))
                    begin
                        lit_pos = '0;
                        name_cand = 13'h1FFF;
                        cur_hdr = HDR_NONE;
                        advance_name(b);
                        cls = CLS_NAME;
                        phase = PH_NAME;
                    end
                    else if (b == CH_CR)
                    begin
                        cls = CLS_BREAK;
                        phase = PH_END_LF;
                    end
                    else
                        err = ERR_HDR;
                PH_NAME:
                    if (name_byte(b))
                    begin
                        advance_name(b);
                        cls = CLS_NAME;
                    end
                    else if (b == CH_COLON)
                    begin
                        cur_hdr = HDR_NONE;
                        for (int k = NUM_HDRS - 1; k >= 0; k--)
                            if (name_cand[k] && lit_pos == name_length(k))
                                cur_hdr = 4'(k);
                        nonempty = 1'b0;
                        phase = PH_VALUE;
                        cls = CLS_SEP;
                        hid = cur_hdr;
                    end
                    else
                        err = ERR_HDR;
                PH_VALUE:
                    if (b == CH_SPACE && !nonempty)
                    begin
                        cls = CLS_SEP;
                        hid = cur_hdr;
                    end
                    else if (b >= 8'h20 && b <= 8'h7E)
                    begin
                        cls = CLS_VALUE;
                        hid = cur_hdr;
                        nonempty = 1'b1;
                    end
                    else if (b == CH_CR)
                    begin
                        if (nonempty)
                        begin
                            cls = CLS_BREAK;
                            phase = PH_VAL_LF;
                        end
                        else
                            err = ERR_EMPTY;
                    end
                    else
                        err = ERR_HDR;
                PH_VAL_LF:
                    if (b == CH_LF)
                    begin
                        cls = CLS_BREAK;
                        phase = PH_LINE;
                    end
                    else
                        err = ERR_HDR;
                PH_END_LF:
                    if (b == CH_LF)
                    begin
                        cls = CLS_BREAK;
                        done = 1'b1;
                        phase = PH_DONE;
                    end
                    else
                        err = ERR_HDR;
                default: ;
            endcase
            if (err != ERR_NONE)
            begin
                err_state = err;
                cls = CLS_METHOD;
                hid = HDR_NONE;
            end
        end
        r.token_class = cls;
        r.header_id = hid;
        r.method_code = cur_method;
        r.protocol_code = cur_proto;
        r.head_done = done;
        r.parse_error = (err_state != ERR_NONE);
        r.error_kind = err_state;
        return r;
    endfunction

    result_t got;
    result_t want;

    assign got = '{token_class, header_id, method_code, protocol_code,
                   head_done, parse_error, error_kind};

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_results.delete();
            failures <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: mismatch expected cls=%0d hid=%0d meth=%0d ",
                                  "proto=%0d done=%0d err=%0d kind=%0d actual cls=%0d ",
                                  "hid=%0d meth=%0d proto=%0d done=%0d err=%0d kind=%0d"},
                                 $time, want.token_class, want.header_id, want.method_code,
                                 want.protocol_code, want.head_done, want.parse_error,
                                 want.error_kind, got.token_class, got.header_id,
                                 got.method_code, got.protocol_code, got.head_done,
                                 got.parse_error, got.error_kind);
                        failures <= failures + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(),
                                        parse_byte(data_byte, restart));
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request head parser testbench
// Sends directed and random request heads, well formed and broken, with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import hrhp_pkg::*;

    logic       clk = 0;
    logic       rst_n = 0;
    logic       in_valid = 0;
    logic       in_ready;
    logic [7:0] data_byte = 0;
    logic       restart = 0;
    logic       out_valid;
    logic       out_ready = 0;
    logic [2:0] token_class;
    logic [3:0] header_id;
    logic [1:0] method_code;
    logic       protocol_code;
    logic       head_done;
    logic       parse_error;
    logic [1:0] error_kind;
    int         failures;
    int         pending;
    int         cycles = 0;
    int         sent = 0;
    bit         calm = 0;

    localparam int LIMIT = 400000;

    always #10 clk = ~clk;

    http_request_head_parser_unit dut (.*);

    hrhp_checker chk (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= calm || ($urandom_range(99) >= 9);
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(input logic [7:0] b, input logic rs);
        bit taken;
        while (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        data_byte <= b;
        restart <= rs;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic send_text(input string s, input logic first_restart);
        for (int i = 0; i < s.len(); i++)
            send(s[i], first_restart && i == 0);
    endtask

    function automatic string random_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1))
                r[i] = r[i] - 8'h20;
        return r;
    endfunction

    function automatic string random_run(input int n, input int lo, input int hi);
        string r;
        r = "";
        for (int i = 0; i < n; i++)
            r = {r, string'(8'($urandom_range(hi, lo)))};
        return r;
    endfunction

    function automatic string random_head();
        string known[13];
        string methods[3];
        string s;
        string nm;
        known = '{"connection", "content-length", "transfer-encoding", "host",
                  "accept", "user-agent", "accept-encoding", "accept-language",
                  "if-none-match", "cache-control", "content-type", "referer",
                  "origin"};
        methods = '{"GET", "HEAD", "POST"};
        s = {methods[$urandom_range(2)], " ", random_run($urandom_range(6, 1), 8'h21, 8'h7E),
             " HTTP/1.", ($urandom_range(1) ? "1" : "0"), "\r\n"};
        repeat ($urandom_range(4))
        begin
            case ($urandom_range(3))
                0: nm = random_run($urandom_range(5, 1), "a", "z");
                1: nm = {known[$urandom_range(12)], "x"};
                default: nm = random_case(known[$urandom_range(12)]);
            endcase
            s = {s, nm, ":", random_run($urandom_range(2), " ", " "),
                 random_run($urandom_range(5, 1), 8'h20, 8'h7E), "\r\n"};
        end
        return {s, "\r\n"};
    endfunction

    initial
    begin
        string h;
        int    p;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        calm = 1;
        send_text("GET / HTTP/1.1\r\nHOST:x\r\n\r\nZ", 1);
        send_text("HEAD /a HTTP/1.0\r\nX-aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa: \r\n", 1);
        send(8'hFF, 1);
        send(8'h00, 1);
        in_valid <= 0;
        calm = 0;
        while (pending != 0)
            @(posedge clk);
        while (sent < 1900)
        begin
            calm = (sent > 900 && sent < 1200);
            h = random_head();
            p = ($urandom_range(9) < 2) ? $urandom_range(h.len() - 1) : h.len();
            for (int i = 0; i < h.len(); i++)
                if (i == p)
                    send(8'($urandom), 0);
                else
                    send(h[i], i == 0);
            if ($urandom_range(9) == 0)
                send(8'($urandom), 1'($urandom_range(1)));
        end
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hdl/hrhp_pkg.sv
hdl/hrhp_name_match.sv
hdl/hrhp_core.sv
hdl/http_request_head_parser_unit.sv
dv/hrhp_checker.sv
dv/tb.sv
